FILE: rtl/pic_pkg.sv
`default_nettype none

package pic_pkg;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 24;

   localparam logic [2:0] KIND_WRITE = 3'd0;
   localparam logic [2:0] KIND_READ  = 3'd1;
   localparam logic [2:0] KIND_RAISE = 3'd2;
   localparam logic [2:0] KIND_LOWER = 3'd3;
   localparam logic [2:0] KIND_ACK   = 3'd4;

   localparam logic PORT_CMD  = 1'b0;
   localparam logic PORT_DATA = 1'b1;

   localparam logic [1:0] STEP_NONE = 2'd0;
   localparam logic [1:0] STEP_ICW2 = 2'd1;
   localparam logic [1:0] STEP_ICW3 = 2'd2;
   localparam logic [1:0] STEP_ICW4 = 2'd3;

   localparam logic [7:0] CMD_ICW1_BIT   = 8'h10;
   localparam logic [7:0] CMD_SEL_MASK   = 8'h18;
   localparam logic [7:0] CMD_OCW3_VAL   = 8'h08;
   localparam logic [7:0] OCW2_CODE_MASK = 8'he0;
   localparam logic [7:0] OCW2_NS_EOI    = 8'h20;
   localparam logic [7:0] MASK_RESET     = 8'hff;
   localparam logic [7:0] BASE_RESET     = 8'h08;

   typedef struct packed {
      logic       found;
      logic [2:0] index;
   } lowest_type;

   function automatic lowest_type lowest_bit(input logic [7:0] v);
      lowest_type r;
      r = '{found: 1'b0, index: 3'd0};
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            r.found = 1'b1;
            r.index = 3'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/programmable_interrupt_controller_core.sv
// A result beat appears in the cycle after its request beat is accepted. All
// updates and the priority encode sit between the controller registers and a
// single result register; one request beat per cycle unless the result stalls.
// Reset (synchronous, active high): IRR and ISR clear, mask all set, vector
// base 0x08, no initialization in progress, status reads disabled.
`default_nettype none

module programmable_interrupt_controller_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // data [7:0], irq_line [10:8], zero [15:11]
   input  wire logic [pic_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind [2:0], port [3]
   input  wire logic [pic_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // read_data [7:0], vector [16:8], irq_pending [17], zero [23:18]
   output logic [pic_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // vector_valid [0]
   output logic                                   rsp_tuser
);

   logic [7:0] irr_ff, irr_in;
   logic [7:0] isr_ff, isr_in;
   logic [7:0] imr_ff, imr_in;
   logic [7:0] base_ff, base_in;
   logic       init_active_ff, init_active_in;
   logic [1:0] init_step_ff, init_step_in;
   logic [1:0] init_mode_ff, init_mode_in;
   logic [1:0] read_ctl_ff, read_ctl_in;

   logic                          rsp_valid_ff;
   logic [pic_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_vv_ff, rsp_vv_in;

   logic       accept;
   logic [2:0] kind;
   logic       port;
   logic [7:0] data;
   logic [2:0] line;

   assign kind = req_tuser[2:0];
   assign port = req_tuser[3];
   assign data = req_tdata[7:0];
   assign line = req_tdata[10:8];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      pic_pkg::lowest_type eoi_hit;
      pic_pkg::lowest_type ack_hit;
      logic [7:0] rd;
      logic [8:0] vec;
      logic       vv;
      logic       pending;

      irr_in         = irr_ff;
      isr_in         = isr_ff;
      imr_in         = imr_ff;
      base_in        = base_ff;
      init_active_in = init_active_ff;
      init_step_in   = init_step_ff;
      init_mode_in   = init_mode_ff;
      read_ctl_in    = read_ctl_ff;
      rd             = 8'd0;
      vec            = 9'd0;
      vv             = 1'b0;
      eoi_hit        = pic_pkg::lowest_bit(isr_ff);
      ack_hit        = pic_pkg::lowest_bit(irr_ff & ~imr_ff);

      unique case (kind)
         pic_pkg::KIND_WRITE: begin
            if (port == pic_pkg::PORT_CMD) begin
               if ((data & pic_pkg::CMD_ICW1_BIT) != 8'd0) begin
                  init_active_in = 1'b1;
                  init_step_in   = pic_pkg::STEP_ICW2;
                  init_mode_in   = data[1:0];
                  imr_in         = 8'd0;
                  isr_in         = 8'd0;
                  irr_in         = 8'd0;
               end else if ((data & pic_pkg::CMD_SEL_MASK) == 8'd0) begin
                  if ((data & pic_pkg::OCW2_CODE_MASK) == pic_pkg::OCW2_NS_EOI
                      && eoi_hit.found) begin
                     isr_in[eoi_hit.index] = 1'b0;
                  end
               end else if ((data & pic_pkg::CMD_SEL_MASK) == pic_pkg::CMD_OCW3_VAL) begin
                  read_ctl_in = data[1:0];
               end
            end else if (!init_active_ff) begin
               imr_in = data;
            end else begin
               unique case (init_step_ff)
                  pic_pkg::STEP_ICW2: begin
                     base_in = data;
                     if (!init_mode_ff[1]) begin
                        init_step_in = pic_pkg::STEP_ICW3;
                     end else if (init_mode_ff[0]) begin
                        init_step_in = pic_pkg::STEP_ICW4;
                     end else begin
                        init_active_in = 1'b0;
                        init_step_in   = pic_pkg::STEP_NONE;
                     end
                  end
                  pic_pkg::STEP_ICW3: begin
                     if (init_mode_ff[0]) begin
                        init_step_in = pic_pkg::STEP_ICW4;
                     end else begin
                        init_active_in = 1'b0;
                        init_step_in   = pic_pkg::STEP_NONE;
                     end
                  end
                  pic_pkg::STEP_ICW4: begin
                     init_active_in = 1'b0;
                     init_step_in   = pic_pkg::STEP_NONE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pic_pkg::KIND_READ: begin
            if (port == pic_pkg::PORT_CMD) begin
               if (read_ctl_ff[1]) begin
                  rd = read_ctl_ff[0] ? isr_ff : irr_ff;
               end
            end else begin
               rd = imr_ff;
            end
         end
         pic_pkg::KIND_RAISE: begin
            irr_in[line] = 1'b1;
         end
         pic_pkg::KIND_LOWER: begin
            irr_in[line] = 1'b0;
         end
         pic_pkg::KIND_ACK: begin
            if (ack_hit.found) begin
               irr_in[ack_hit.index] = 1'b0;
               isr_in[ack_hit.index] = 1'b1;
               vv  = 1'b1;
               vec = {1'b0, base_ff} + {6'd0, ack_hit.index};
            end
         end
         default: begin
         end
      endcase

      pending     = (irr_in & ~imr_in) != 8'd0;
      rsp_data_in = {6'd0, pending, vec, rd};
      rsp_vv_in   = vv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irr_ff         <= 8'd0;
         isr_ff         <= 8'd0;
         imr_ff         <= pic_pkg::MASK_RESET;
         base_ff        <= pic_pkg::BASE_RESET;
         init_active_ff <= 1'b0;
         init_step_ff   <= pic_pkg::STEP_NONE;
         init_mode_ff   <= 2'd0;
         read_ctl_ff    <= 2'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            irr_ff         <= irr_in;
            isr_ff         <= isr_in;
            imr_ff         <= imr_in;
            base_ff        <= base_in;
            init_active_ff <= init_active_in;
            init_step_ff   <= init_step_in;
            init_mode_ff   <= init_mode_in;
            read_ctl_ff    <= read_ctl_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_vv_ff   <= rsp_vv_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_vv_ff;

endmodule

`default_nettype wire

FILE: rtl/pic_checker.sv
`default_nettype none

module pic_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [pic_pkg::REQ_USER_W-1:0]    req_tuser,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [pic_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire logic                              rsp_tuser
);

   logic req_beat;
   assign req_beat = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_no_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[16:8] == 9'd0)
      else $error("vector nonzero without vector_valid");

   a_read_only: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_tuser[2:0] != pic_pkg::KIND_READ
      |=> rsp_tvalid && rsp_tdata[7:0] == 8'd0)
      else $error("read data on a non-read beat");

   a_ack_only: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_tuser[2:0] != pic_pkg::KIND_ACK |=> rsp_tvalid && !rsp_tuser)
      else $error("vector_valid on a non-acknowledge beat");

endmodule

bind programmable_interrupt_controller_core pic_checker u_pic_checker (.*);

`default_nettype wire
